// ----- design/ftled_pkg.sv -----
// ----------------------------------------------------------------------------
// ftled_pkg
// Shared types, constants and codes of the falling trace LED frame generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ftled_pkg;

	localparam int unsigned MAX_LEDS = 64;
	localparam int unsigned LC_W     = 7;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned HEAD_W   = 10;
	localparam int unsigned HOLD_W   = 9;
	localparam int unsigned SLOT_W   = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned PROD_W   = HEAD_W + BYTE_W;

	localparam int unsigned JOB_DEPTH = 2;
	localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	localparam logic [LC_W-1:0]   LED_COUNT_RST   = LC_W'(MAX_LEDS);
	localparam logic [BYTE_W-1:0] FADE_STEP_RST   = 8'd16;
	localparam logic [BYTE_W-1:0] HOLD_FRAMES_RST = 8'd4;
	localparam logic [BYTE_W-1:0] FULL_BRIGHT     = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LED_COUNT   = 2'd0,
		REG_FADE_STEP   = 2'd1,
		REG_HOLD_FRAMES = 2'd2
	} cfg_reg_t;

	typedef enum logic [SLOT_W-1:0] {
		SLOT_GREEN = 2'd0,
		SLOT_RED   = 2'd1,
		SLOT_BLUE  = 2'd2
	} slot_code_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_PUSH
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_RUN
	} back_state_t;

	// one frame worth of work handed from front to back
	typedef struct packed {
		logic [LC_W-1:0]          led_count;
		logic [BYTE_W-1:0]        fade;
		logic signed [HEAD_W-1:0] head;
		logic [SLOT_W-1:0]        slot;
		logic [BYTE_W-1:0]        bright;
	} frame_job_t;

	// handshake between the job queue and its two sides
	typedef struct packed {
		logic push;
		logic pop;
	} job_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} job_stat_t;

endpackage

`default_nettype wire

// ----- design/ftled_front.sv -----
// ----------------------------------------------------------------------------
// ftled_front
// Accepts frame ticks, snapshots the frame setup, computes the first pixel
// brightness and advances head, hold count and colour slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ftled_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             frame_tick,
	input  wire logic [ftled_pkg::LC_W-1:0]       led_count,
	input  wire logic [ftled_pkg::BYTE_W-1:0]     fade_step,
	input  wire logic [ftled_pkg::BYTE_W-1:0]     hold_frames,
	input  wire ftled_pkg::job_stat_t             job_stat,
	output logic                                  job_push,
	output ftled_pkg::frame_job_t                 job
);

	ftled_pkg::front_state_t state_q, state_nx;

	logic signed [ftled_pkg::HEAD_W-1:0] head_q;
	logic [ftled_pkg::HOLD_W-1:0]        hold_q;
	logic [ftled_pkg::SLOT_W-1:0]        slot_q;

	logic [ftled_pkg::LC_W-1:0]   lc_s1;
	logic [ftled_pkg::BYTE_W-1:0] fade_s1;
	logic [ftled_pkg::PROD_W-1:0] prod_s2;
	logic                         dneg_s2;
	logic                         dpos_s2;

	logic signed [ftled_pkg::HEAD_W:0] span;
	logic                              take;
	logic                              done;
	logic                              over;
	logic [ftled_pkg::BYTE_W-1:0]      bright;

	assign take = in_valid && !in_stall && frame_tick;
	assign span = (ftled_pkg::HEAD_W+1)'(1) - (ftled_pkg::HEAD_W+1)'(head_q);
	assign over = (prod_s2 > ftled_pkg::PROD_W'(ftled_pkg::FULL_BRIGHT));
	assign bright = (dneg_s2 || over) ? '0 : (ftled_pkg::FULL_BRIGHT - prod_s2[7:0]);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ftled_pkg::F_IDLE: begin
				if (take) begin
					state_nx = ftled_pkg::F_CALC;
				end
			end
			ftled_pkg::F_CALC: begin
				state_nx = ftled_pkg::F_PUSH;
			end
			ftled_pkg::F_PUSH: begin
				if (done) begin
					state_nx = ftled_pkg::F_IDLE;
				end
			end
			default: begin
				state_nx = ftled_pkg::F_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		job_push = 1'b0;
		done     = 1'b0;
		case (state_q)
			ftled_pkg::F_IDLE: begin
				in_stall = 1'b0;
			end
			ftled_pkg::F_PUSH: begin
				done     = (lc_s1 == '0) || !job_stat.full;
				job_push = (lc_s1 != '0) && !job_stat.full;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign job.led_count = lc_s1;
	assign job.fade      = fade_s1;
	assign job.head      = head_q;
	assign job.slot      = slot_q;
	assign job.bright    = bright;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftled_pkg::F_IDLE;
			head_q  <= '0;
			hold_q  <= '0;
			slot_q  <= ftled_pkg::SLOT_GREEN;
		end else begin
			state_q <= state_nx;
			if (done) begin
				if (hold_q > {1'b0, hold_frames}) begin
					hold_q <= '0;
					if (dpos_s2 && over) begin
						head_q <= signed'(ftled_pkg::HEAD_W'(lc_s1));
						slot_q <= (slot_q < ftled_pkg::SLOT_BLUE) ? slot_q + 2'd1
							: ftled_pkg::SLOT_GREEN;
					end else begin
						head_q <= head_q - ftled_pkg::HEAD_W'(1);
					end
				end else begin
					hold_q <= hold_q + ftled_pkg::HOLD_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lc_s1   <= (led_count > ftled_pkg::LC_W'(ftled_pkg::MAX_LEDS))
				? ftled_pkg::LC_W'(ftled_pkg::MAX_LEDS) : led_count;
			fade_s1 <= (fade_step == '0) ? ftled_pkg::BYTE_W'(1) : fade_step;
		end
		if (state_q == ftled_pkg::F_CALC) begin
			prod_s2 <= ftled_pkg::PROD_W'(span[ftled_pkg::HEAD_W-1:0])
				* ftled_pkg::PROD_W'(fade_s1);
			dneg_s2 <= span[ftled_pkg::HEAD_W];
			dpos_s2 <= !span[ftled_pkg::HEAD_W] && (span != '0);
		end
	end

endmodule

`default_nettype wire

// ----- design/ftled_fifo.sv -----
// ----------------------------------------------------------------------------
// ftled_fifo
// Short queue of frame jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ftled_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ftled_pkg::job_ctrl_t   ctrl,
	input  wire ftled_pkg::frame_job_t  wr_job,
	output ftled_pkg::job_stat_t        stat,
	output ftled_pkg::frame_job_t       rd_job
);

	ftled_pkg::frame_job_t mem_q [ftled_pkg::JOB_DEPTH];

	logic [ftled_pkg::JOB_PTR_W-1:0] wr_ptr_q;
	logic [ftled_pkg::JOB_PTR_W-1:0] rd_ptr_q;
	logic [ftled_pkg::JOB_CNT_W-1:0] count_q;
	logic                            do_push;
	logic                            do_pop;

	assign stat.full  = (count_q == ftled_pkg::JOB_CNT_W'(ftled_pkg::JOB_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = ctrl.push && !stat.full;
	assign do_pop  = ctrl.pop && !stat.empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == ftled_pkg::JOB_PTR_W'(ftled_pkg::JOB_DEPTH - 1))
					? '0 : wr_ptr_q + ftled_pkg::JOB_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == ftled_pkg::JOB_PTR_W'(ftled_pkg::JOB_DEPTH - 1))
					? '0 : rd_ptr_q + ftled_pkg::JOB_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + ftled_pkg::JOB_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - ftled_pkg::JOB_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ftled_pkg::JOB_CNT_W'(ftled_pkg::JOB_DEPTH))
		else $error("job queue count above depth");

endmodule

`default_nettype wire

// ----- design/ftled_back.sv -----
// ----------------------------------------------------------------------------
// ftled_back
// Walks one frame job LED by LED and presents one pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ftled_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ftled_pkg::job_stat_t         job_stat,
	input  wire ftled_pkg::frame_job_t        job,
	output logic                              job_pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [ftled_pkg::LC_W-1:0]        led_number,
	output logic [ftled_pkg::BYTE_W-1:0]      first_byte,
	output logic [ftled_pkg::BYTE_W-1:0]      second_byte,
	output logic [ftled_pkg::BYTE_W-1:0]      third_byte,
	output logic                              last
);

	ftled_pkg::back_state_t state_q, state_nx;

	logic [ftled_pkg::LC_W-1:0]          idx_q;
	logic [ftled_pkg::BYTE_W-1:0]        bright_q;
	logic [ftled_pkg::LC_W-1:0]          lc_q;
	logic [ftled_pkg::BYTE_W-1:0]        fade_q;
	logic signed [ftled_pkg::HEAD_W-1:0] head_q;
	logic [ftled_pkg::SLOT_W-1:0]        slot_q;

	logic [ftled_pkg::LC_W-1:0]   idx_nx;
	logic [ftled_pkg::BYTE_W-1:0] bright_nx;
	logic [ftled_pkg::BYTE_W-1:0] dim;
	logic                         xfer;
	logic                         hit_nx;
	logic                         at_head;

	assign xfer    = out_valid && !out_stall;
	assign idx_nx  = idx_q + ftled_pkg::LC_W'(1);
	assign hit_nx  = (head_q == signed'(ftled_pkg::HEAD_W'(idx_nx)));
	assign at_head = (head_q == signed'(ftled_pkg::HEAD_W'(idx_q)));
	assign bright_nx = hit_nx ? ftled_pkg::FULL_BRIGHT
		: ((bright_q >= fade_q) ? bright_q - fade_q : '0);
	assign dim = bright_q >> 3;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ftled_pkg::B_IDLE: begin
				if (!job_stat.empty) begin
					state_nx = ftled_pkg::B_RUN;
				end
			end
			ftled_pkg::B_RUN: begin
				if (xfer && last) begin
					state_nx = ftled_pkg::B_IDLE;
				end
			end
			default: begin
				state_nx = ftled_pkg::B_IDLE;
			end
		endcase
	end

	always_comb begin
		job_pop   = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ftled_pkg::B_IDLE: begin
				job_pop = !job_stat.empty;
			end
			ftled_pkg::B_RUN: begin
				out_valid = 1'b1;
			end
			default: begin
				out_valid = 1'b0;
			end
		endcase
	end

	assign led_number  = idx_q;
	assign last        = (idx_q == lc_q);
	assign first_byte  = (slot_q == ftled_pkg::SLOT_GREEN) ? bright_q : dim;
	assign second_byte = (slot_q == ftled_pkg::SLOT_RED) ? bright_q : dim;
	assign third_byte  = ((slot_q != ftled_pkg::SLOT_GREEN) && (slot_q != ftled_pkg::SLOT_RED))
		? bright_q : dim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftled_pkg::B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			idx_q    <= ftled_pkg::LC_W'(1);
			bright_q <= job.bright;
			lc_q     <= job.led_count;
			fade_q   <= job.fade;
			head_q   <= job.head;
			slot_q   <= job.slot;
		end else if (xfer) begin
			idx_q    <= idx_nx;
			bright_q <= bright_nx;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q != '0) && (idx_q <= lc_q))
		else $error("pixel number outside the strip");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=>
		(out_valid && (idx_q == $past(idx_q) + ftled_pkg::LC_W'(1))))
		else $error("pixel sequence broken inside a frame");

	a_head_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && at_head) |-> (bright_q == ftled_pkg::FULL_BRIGHT))
		else $error("head pixel not at full brightness");

endmodule

`default_nettype wire

// ----- design/falling_trace_led_frame_generator_unit.sv -----
// ----------------------------------------------------------------------------
// falling_trace_led_frame_generator_unit
// Frame generator for a falling trace with a fading tail on an LED strip.
// ----------------------------------------------------------------------------
// Each accepted frame tick with frame_tick high yields one pixel transfer per
// LED, led_number 1 up to the LED count, with last on the final one; a tick
// with frame_tick low yields nothing. The front takes a tick while idle,
// multiplies for the tail in its calc state and queues the frame from its
// push state, taking no new tick while it waits for room in the two-entry
// frame queue. Within a frame the back emits one pixel per cycle while the
// receiver does not stall. Configuration writes take effect on the next tick.
// ----------------------------------------------------------------------------
`default_nettype none

module falling_trace_led_frame_generator_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [ftled_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ftled_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  frame_tick,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [ftled_pkg::LC_W-1:0]                 led_number,
	output logic [ftled_pkg::BYTE_W-1:0]               first_byte,
	output logic [ftled_pkg::BYTE_W-1:0]               second_byte,
	output logic [ftled_pkg::BYTE_W-1:0]               third_byte,
	output logic                                       last
);

	logic [ftled_pkg::LC_W-1:0]   led_count_q;
	logic [ftled_pkg::BYTE_W-1:0] fade_step_q;
	logic [ftled_pkg::BYTE_W-1:0] hold_frames_q;

	ftled_pkg::job_ctrl_t  job_ctrl;
	ftled_pkg::job_stat_t  job_stat;
	ftled_pkg::frame_job_t wr_job;
	ftled_pkg::frame_job_t rd_job;
	logic                  job_push;
	logic                  job_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q   <= ftled_pkg::LED_COUNT_RST;
			fade_step_q   <= ftled_pkg::FADE_STEP_RST;
			hold_frames_q <= ftled_pkg::HOLD_FRAMES_RST;
		end else if (cfg_we) begin
			case (ftled_pkg::cfg_reg_t'(cfg_index))
				ftled_pkg::REG_LED_COUNT: begin
					led_count_q <= cfg_data[ftled_pkg::LC_W-1:0];
				end
				ftled_pkg::REG_FADE_STEP: begin
					fade_step_q <= cfg_data;
				end
				ftled_pkg::REG_HOLD_FRAMES: begin
					hold_frames_q <= cfg_data;
				end
				default: begin
					hold_frames_q <= hold_frames_q;
				end
			endcase
		end
	end

	assign job_ctrl.push = job_push;
	assign job_ctrl.pop  = job_pop;

	ftled_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_tick  (frame_tick),
		.led_count   (led_count_q),
		.fade_step   (fade_step_q),
		.hold_frames (hold_frames_q),
		.job_stat    (job_stat),
		.job_push    (job_push),
		.job         (wr_job)
	);

	ftled_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (job_ctrl),
		.wr_job (wr_job),
		.stat   (job_stat),
		.rd_job (rd_job)
	);

	ftled_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_stat    (job_stat),
		.job         (rd_job),
		.job_pop     (job_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_number  (led_number),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.third_byte  (third_byte),
		.last        (last)
	);

endmodule

`default_nettype wire

// ----- sim/falling_trace_led_frame_generator_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_trace_led_frame_generator_unit_test
// Self-checking bench for the falling trace LED frame generator.
// ----------------------------------------------------------------------------
// Frame ticks are driven from a queue. Every accepted high tick updates a local
// model of the head, hold counter and colour slot and queues the pixels the
// frame should produce. Each pixel transfer is checked field by field against
// the oldest queued pixel. Runs a short directed set (no tick, zero and
// oversized LED count, zero fade, head above the strip, hold extremes), then
// random register settings with sender gaps and receiver stalls, plus one
// long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module falling_trace_led_frame_generator_unit_test;

	import ftled_pkg::*;

	localparam int SETTLE_CYCLES  = 160;
	localparam int HOLDOFF_CYCLES = 400;

	typedef enum int {
		PACE_FULL,
		PACE_SENDER_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic [LC_W-1:0]   led;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic              tail_end;
	} pixel_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic                  frame_tick = 1'b0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [LC_W-1:0]       led_number;
	logic [BYTE_W-1:0]     first_byte;
	logic [BYTE_W-1:0]     second_byte;
	logic [BYTE_W-1:0]     third_byte;
	logic                  last;

	// frame model state
	logic [LC_W-1:0]          cfg_leds = LED_COUNT_RST;
	logic [BYTE_W-1:0]        cfg_fade = FADE_STEP_RST;
	logic [BYTE_W-1:0]        cfg_hold = HOLD_FRAMES_RST;
	logic signed [HEAD_W-1:0] head_pos = '0;
	logic [HOLD_W-1:0]        hold_cnt = '0;
	logic [SLOT_W-1:0]        slot     = SLOT_GREEN;

	logic   tick_queue[$];
	pixel_t pixel_queue[$];

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   mismatch_count = 0;
	logic holdoff_arm    = 1'b0;
	int   holdoff_left   = 0;

	falling_trace_led_frame_generator_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_tick  (frame_tick),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_number  (led_number),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.third_byte  (third_byte),
		.last        (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// queue the pixels of one frame and advance head, hold and colour
	task automatic render_frame(input logic tick);
		int fade, leds, lowest, pos, lvl, dim, h;
		pixel_t px;
		if (!tick) return;
		fade   = (cfg_fade == 0) ? 1 : int'(cfg_fade);
		leds   = (cfg_leds > MAX_LEDS) ? int'(MAX_LEDS) : int'(cfg_leds);
		lowest = -(255 / fade);
		lvl    = 0;
		for (pos = lowest; pos <= leds; pos++) begin
			if (pos == head_pos) lvl = 255;
			else if (lvl >= fade) lvl = lvl - fade;
			else lvl = 0;
			if (pos > 0) begin
				dim         = lvl >> 3;
				px.led      = LC_W'(pos);
				px.b0       = (slot == SLOT_GREEN) ? BYTE_W'(lvl) : BYTE_W'(dim);
				px.b1       = (slot == SLOT_RED) ? BYTE_W'(lvl) : BYTE_W'(dim);
				px.b2       = (slot != SLOT_GREEN && slot != SLOT_RED) ?
				              BYTE_W'(lvl) : BYTE_W'(dim);
				px.tail_end = (pos == leds);
				pixel_queue.push_back(px);
			end
		end
		if (hold_cnt > cfg_hold) begin
			hold_cnt = '0;
			h = head_pos;
			h = h - 1;
			if (h < lowest) begin
				h = leds;
				case (slot)
					SLOT_GREEN: slot = SLOT_RED;
					SLOT_RED:   slot = SLOT_BLUE;
					default:    slot = SLOT_GREEN;
				endcase
			end
			head_pos = HEAD_W'(h);
		end else begin
			hold_cnt = hold_cnt + 1'b1;
		end
	endtask

	// tick driver
	always @(posedge clk) begin
		logic take;
		take = in_valid && !in_stall;
		if (take) render_frame(frame_tick);
		if (arst_n && (!in_valid || take) && tick_queue.size() != 0 &&
		    $urandom_range(99) >= send_idle_pct) begin
			in_valid   <= 1'b1;
			frame_tick <= tick_queue.pop_front();
		end else if (take) begin
			in_valid <= 1'b0;
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (holdoff_arm) holdoff_left <= HOLDOFF_CYCLES;
		else if (holdoff_left != 0) holdoff_left <= holdoff_left - 1;
	end

	// pixel monitor
	always @(posedge clk) begin
		pixel_t want;
		if (out_valid && !out_stall) begin
			if (pixel_queue.size() == 0) begin
				note_mismatch($sformatf("pixel transfer for led %0d with nothing expected",
				                        led_number));
			end else begin
				want = pixel_queue.pop_front();
				if (led_number !== want.led)
					note_mismatch($sformatf("led_number %0d, expected %0d",
					                        led_number, want.led));
				if (first_byte !== want.b0)
					note_mismatch($sformatf("led %0d first_byte %0d, expected %0d",
					                        want.led, first_byte, want.b0));
				if (second_byte !== want.b1)
					note_mismatch($sformatf("led %0d second_byte %0d, expected %0d",
					                        want.led, second_byte, want.b1));
				if (third_byte !== want.b2)
					note_mismatch($sformatf("led %0d third_byte %0d, expected %0d",
					                        want.led, third_byte, want.b2));
				if (last !== want.tail_end)
					note_mismatch($sformatf("led %0d last %0b, expected %0b",
					                        want.led, last, want.tail_end));
			end
		end
		out_stall <= arst_n && (holdoff_left != 0 || $urandom_range(99) < recv_stall_pct);
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_LED_COUNT:   cfg_leds = val[LC_W-1:0];
			REG_FADE_STEP:   cfg_fade = val;
			REG_HOLD_FRAMES: cfg_hold = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_pace(input pace_t pace);
		@(negedge clk);
		case (pace)
			PACE_SENDER_IDLE: begin send_idle_pct = 66; recv_stall_pct = 0;  end
			PACE_RECV_STALL:  begin send_idle_pct = 0;  recv_stall_pct = 66; end
			PACE_BOTH:        begin send_idle_pct = 6;  recv_stall_pct = 6;  end
			default:          begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		endcase
	endtask

	task automatic queue_ticks(input int n, input int zero_pct);
		int k;
		@(negedge clk);
		for (k = 0; k < n; k++) tick_queue.push_back($urandom_range(99) >= zero_pct);
	endtask

	// wait for every pixel, then give the block time to finish silent frames
	task automatic settle();
		do @(negedge clk);
		while (tick_queue.size() != 0 || in_valid || pixel_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] leds, fade, hold,
	                         input pace_t pace, input int n, input int zero_pct);
		set_pace(pace);
		write_reg(REG_LED_COUNT, leds);
		write_reg(REG_FADE_STEP, fade);
		write_reg(REG_HOLD_FRAMES, hold);
		queue_ticks(n, zero_pct);
		settle();
	endtask

	initial begin
		int ph;
		logic [CFG_DATA_W-1:0] leds, fade, hold;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, a frame request with no tick first
		set_pace(PACE_FULL);
		@(negedge clk);
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b1);
		tick_queue.push_back(1'b1);
		settle();
		// zero led count: nothing out, head still wraps (to zero)
		run_phase(8'd0, 8'd255, 8'd0, PACE_FULL, 3, 0);
		// zero fade acts as one, single led
		run_phase(8'd1, 8'd0, 8'd0, PACE_RECV_STALL, 2, 0);
		// oversized led count, head wraps to the far end
		run_phase(8'hFF, 8'd255, 8'd0, PACE_SENDER_IDLE, 2, 0);
		// head now above a short strip
		run_phase(8'd9, 8'd255, 8'd0, PACE_BOTH, 2, 0);
		// full strip, longest hold
		run_phase(8'd64, 8'd16, 8'd255, PACE_FULL, 3, 0);

		// receiver holds off while ticks keep coming
		set_pace(PACE_FULL);
		write_reg(REG_HOLD_FRAMES, 8'd1);
		@(posedge clk);
		holdoff_arm <= 1'b1;
		@(posedge clk);
		holdoff_arm <= 1'b0;
		queue_ticks(8, 0);
		settle();

		for (ph = 0; ph < 12; ph++) begin
			leds = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
			       ($urandom_range(3) == 0) ? 8'($urandom_range(17, 64)) :
			                                  8'($urandom_range(1, 16));
			fade = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
			                                  8'($urandom_range(64, 255));
			hold = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
			                                  8'($urandom_range(2));
			run_phase(leds, fade, hold, pace_t'(ph % 4), 18, 10);
		end

		if (mismatch_count == 0) begin
			$display("falling_trace_led_frame_generator_unit_test: PASS");
		end else begin
			$display("falling_trace_led_frame_generator_unit_test: FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("falling_trace_led_frame_generator_unit_test: FAIL");
		$finish;
	end

endmodule
